>>> src/rld_pkg.sv
// Shared types, constants and table functions for the ring longest-run direction finder.
`timescale 1ns / 1ps

package rld_pkg;

	// default ring size
	localparam int SENSORS_DEFAULT = 16;

	// internal angle units: 1/16384 degree
	localparam longint FULL_TURN    = 64'sd5898240;
	localparam longint HALF_TURN    = 64'sd2949120;
	localparam longint QUARTER_TURN = 64'sd1474560;
	localparam longint INV_GAIN_Q30 = 64'sd652032874;

	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam int ATAN_W       = 20;
	localparam int ANGLE_W      = 24;	// signed internal angle accumulator
	localparam int DIR_W        = 15;
	localparam int DIR_UNITS    = 23040;
	localparam int UNIT_W       = 16;	// Q1.14 plus sign

	typedef struct packed {
		logic [15:0] sensor_bitmap;
	} rld_in_t;

	typedef struct packed {
		logic [4:0]       run_length;
		logic [3:0]       run_start;
		logic             ball_seen;
		logic [DIR_W-1:0] direction;
	} rld_out_t;

	// arctangent of 2^-k in internal angle units
	function automatic logic [ATAN_W-1:0] atan_step(input logic [STEP_W-1:0] k);
		logic [ATAN_W-1:0] v;
		unique case (k)
			4'd0:    v = 20'd737280;
			4'd1:    v = 20'd435242;
			4'd2:    v = 20'd229970;
			4'd3:    v = 20'd116736;
			4'd4:    v = 20'd58595;
			4'd5:    v = 20'd29326;
			4'd6:    v = 20'd14667;
			4'd7:    v = 20'd7334;
			4'd8:    v = 20'd3667;
			4'd9:    v = 20'd1833;
			4'd10:   v = 20'd917;
			4'd11:   v = 20'd458;
			4'd12:   v = 20'd229;
			4'd13:   v = 20'd115;
			4'd14:   v = 20'd57;
			default: v = 20'd29;
		endcase
		return v;
	endfunction

	// Q1.14 cosine or sine of an internal angle; rotation CORDIC in Q2.30,
	// quadrant reduced, rounded half up and clamped. Used for constant tables.
	function automatic logic signed [UNIT_W-1:0] unit_cs(input longint ang, input bit want_sin);
		longint q;
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		longint cr;
		longint sr;
		longint c;
		longint s;
		q = ang / QUARTER_TURN;
		z = ang - q * QUARTER_TURN;
		x = INV_GAIN_Q30;
		y = 0;
		for (int k = 0; k < CORDIC_STEPS; k++) begin
			dx = y >>> k;
			dy = x >>> k;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - longint'(atan_step(STEP_W'(k)));
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + longint'(atan_step(STEP_W'(k)));
			end
		end
		cr = (x + 32768) >>> 16;
		sr = (y + 32768) >>> 16;
		if (cr > 16384) cr = 16384;
		if (cr < -16384) cr = -16384;
		if (sr > 16384) sr = 16384;
		if (sr < -16384) sr = -16384;
		if (q == 0) begin
			c = cr;
			s = sr;
		end else if (q == 1) begin
			c = -sr;
			s = cr;
		end else if (q == 2) begin
			c = -cr;
			s = -sr;
		end else begin
			c = sr;
			s = -cr;
		end
		return want_sin ? UNIT_W'(s) : UNIT_W'(c);
	endfunction

endpackage

>>> src/rld_stream_if.sv
// Valid/ready stream interface carrying one payload beat.
`timescale 1ns / 1ps

interface rld_stream_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> src/rld_vector.sv
// Iterative vectoring CORDIC: angle of the summed unit vectors in 1/64 degree.
`timescale 1ns / 1ps

module rld_vector #(
	parameter int SENSORS = rld_pkg::SENSORS_DEFAULT
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  logic signed [$clog2(SENSORS)+15:0]      sx,
	input  logic signed [$clog2(SENSORS)+15:0]      sy,
	output logic                                    done,
	output logic [rld_pkg::DIR_W-1:0]               direction
);

	localparam int SUMW = $clog2(SENSORS) + 16;
	localparam int CW   = SUMW + 22;	// sums scaled by 2^20 plus CORDIC growth
	localparam int ZW   = rld_pkg::ANGLE_W;
	localparam logic signed [ZW-1:0] FullTurn = ZW'(rld_pkg::FULL_TURN);
	localparam logic signed [ZW-1:0] HalfTurn = ZW'(rld_pkg::HALF_TURN);

	logic                          run_q;
	logic                          fin_q;
	logic                          done_q;
	logic                          zero_q;
	logic [rld_pkg::STEP_W-1:0]    k_q;
	logic signed [CW-1:0]          x_q;
	logic signed [CW-1:0]          y_q;
	logic signed [ZW-1:0]          z_q;
	logic [rld_pkg::DIR_W-1:0]     dir_q;

	logic signed [CW-1:0]          x_init;
	logic signed [CW-1:0]          y_init;
	logic signed [CW-1:0]          dx;
	logic signed [CW-1:0]          dy;
	logic signed [ZW-1:0]          atan_z;
	logic signed [ZW-1:0]          wrapped;
	logic [ZW-1:0]                 rounded;
	logic [rld_pkg::DIR_W-1:0]     dir_raw;

	// scaled start vector
	assign x_init = CW'(sx) <<< 20;
	assign y_init = CW'(sy) <<< 20;

	// shared shift/add step
	assign dx     = y_q >>> k_q;
	assign dy     = x_q >>> k_q;
	assign atan_z = signed'(ZW'(rld_pkg::atan_step(k_q)));

	// wrap into one turn, round half up to 1/64 degree
	always_comb begin
		if (z_q < 0) begin
			wrapped = z_q + FullTurn;
		end else if (z_q >= FullTurn) begin
			wrapped = z_q - FullTurn;
		end else begin
			wrapped = z_q;
		end
		rounded = ZW'(wrapped) + ZW'(128);
		dir_raw = rounded[8 +: rld_pkg::DIR_W];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= fin_q && !start && !run_q;
			if (start) begin
				run_q <= 1'b1;
				k_q   <= '0;
			end else if (run_q) begin
				k_q <= k_q + 1'b1;
				if (k_q == rld_pkg::STEP_W'(rld_pkg::CORDIC_STEPS - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (sx == '0) && (sy == '0);
			if (sx < 0) begin
				x_q <= -x_init;
				y_q <= -y_init;
				z_q <= HalfTurn;
			end else begin
				x_q <= x_init;
				y_q <= y_init;
				z_q <= '0;
			end
		end else if (run_q) begin
			if (y_q > 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_z;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_z;
			end
		end
		if (fin_q) begin
			if (zero_q || dir_raw >= rld_pkg::DIR_W'(rld_pkg::DIR_UNITS)) begin
				dir_q <= '0;
			end else begin
				dir_q <= dir_raw;
			end
		end
	end

	assign done      = done_q;
	assign direction = dir_q;

endmodule

>>> src/ring_longest_run_direction.sv
// Top level: longest circular run of ring hits and its mean direction.
// From accept to result valid for a partial run: one sensor per cycle over two laps,
// one add per run sensor, then the vectoring CORDIC; a clear or full ring skips the
// sums and the CORDIC and goes straight to the result.
// Throughput: one frame at a time; ready again the cycle after the result is registered.
// Reset: arst_n clears the sequencer and the result valid; no state across frames.
`timescale 1ns / 1ps

module ring_longest_run_direction #(
	parameter int SENSORS = rld_pkg::SENSORS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	rld_stream_if.sink   frame,
	rld_stream_if.source result
);

	localparam int IW   = $clog2(SENSORS);
	localparam int KW   = $clog2(2 * SENSORS);
	localparam int BW   = $clog2(2 * SENSORS + 1);
	localparam int LW   = $clog2(SENSORS + 1);
	localparam int SUMW = $clog2(SENSORS) + 16;
	localparam int UW   = rld_pkg::UNIT_W;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SCAN   = 6'b000010,
		ST_PREP   = 6'b000100,
		ST_SUM    = 6'b001000,
		ST_VECT   = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	state_t                     state_q;
	logic                       start_q;
	logic                       res_valid_q;

	logic [SENSORS-1:0]         bits_q;
	logic [KW-1:0]              k_q;
	logic [IW-1:0]              i_q;
	logic [BW-1:0]              cur_len_q;
	logic [IW-1:0]              cur_start_q;
	logic [BW-1:0]              best_len_q;
	logic [IW-1:0]              best_start_q;
	logic [LW-1:0]              len_q;
	logic [LW-1:0]              j_q;
	logic [IW-1:0]              idx_q;
	logic                       seen_q;
	logic signed [SUMW-1:0]     sx_q;
	logic signed [SUMW-1:0]     sy_q;
	logic [rld_pkg::DIR_W-1:0]  dir_q;

	logic [SENSORS-1:0]         bits_ext;
	logic                       hit;
	logic [BW-1:0]              cur_next;
	logic                       scan_last;
	logic                       sum_last;
	logic                       out_free;
	logic                       vec_done;
	logic [rld_pkg::DIR_W-1:0]  vec_dir;
	logic signed [UW-1:0]       cos_tab [SENSORS];
	logic signed [UW-1:0]       sin_tab [SENSORS];

	// unit vector tables, one entry per sensor
	for (genvar g = 0; g < SENSORS; g++) begin : g_tab
		localparam longint Ang =
			(longint'(g) * rld_pkg::FULL_TURN + longint'(SENSORS / 2)) / SENSORS;
		assign cos_tab[g] = rld_pkg::unit_cs(Ang, 1'b0);
		assign sin_tab[g] = rld_pkg::unit_cs(Ang, 1'b1);
	end

	// sensors beyond the 16 input bits read as inactive
	always_comb begin
		for (int b = 0; b < SENSORS; b++) begin
			bits_ext[b] = (b < 16) ? frame.data.sensor_bitmap[b % 16] : 1'b0;
		end
	end

	assign hit       = bits_q[i_q];
	assign cur_next  = cur_len_q + 1'b1;
	assign scan_last = (k_q == KW'(2 * SENSORS - 1));
	assign sum_last  = (j_q + LW'(1) == len_q);
	assign out_free  = !res_valid_q || result.ready;

	assign frame.ready  = (state_q == ST_IDLE);
	assign result.valid = res_valid_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			// kick the CORDIC as the last vector is added
			start_q <= (state_q == ST_SUM) && sum_last;
			if (state_q == ST_FINISH && out_free) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (frame.valid) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_last) state_q <= ST_PREP;
				end
				ST_PREP: begin
					// no ball or a full ring: direction is zero, skip the sums
					if (best_len_q == '0 || best_len_q >= BW'(SENSORS)) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (sum_last) state_q <= ST_VECT;
				end
				ST_VECT: begin
					if (vec_done) state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				bits_q       <= bits_ext;
				k_q          <= '0;
				i_q          <= '0;
				cur_len_q    <= '0;
				cur_start_q  <= '0;
				best_len_q   <= '0;
				best_start_q <= '0;
			end
			ST_SCAN: begin
				// one sensor per cycle over two laps
				k_q <= k_q + 1'b1;
				i_q <= (i_q == IW'(SENSORS - 1)) ? '0 : i_q + 1'b1;
				if (hit) begin
					cur_len_q <= cur_next;
					if (cur_len_q == '0) cur_start_q <= i_q;
					if (cur_next > best_len_q) begin
						best_len_q   <= cur_next;
						best_start_q <= (cur_len_q == '0) ? i_q : cur_start_q;
					end
				end else begin
					cur_len_q <= '0;
				end
			end
			ST_PREP: begin
				len_q  <= (best_len_q > BW'(SENSORS)) ? LW'(SENSORS) : LW'(best_len_q);
				seen_q <= (best_len_q != '0);
				idx_q  <= best_start_q;
				j_q    <= '0;
				sx_q   <= '0;
				sy_q   <= '0;
				dir_q  <= '0;
			end
			ST_SUM: begin
				// one unit vector per cycle around the run
				sx_q  <= sx_q + SUMW'(cos_tab[idx_q]);
				sy_q  <= sy_q + SUMW'(sin_tab[idx_q]);
				idx_q <= (idx_q == IW'(SENSORS - 1)) ? '0 : idx_q + 1'b1;
				j_q   <= j_q + 1'b1;
			end
			ST_VECT: begin
				if (vec_done) dir_q <= vec_dir;
			end
			ST_FINISH: begin
				if (out_free) begin
					result.data.run_length <= 5'(len_q);
					result.data.run_start  <= 4'(best_start_q);
					result.data.ball_seen  <= seen_q;
					result.data.direction  <= dir_q;
				end
			end
			default: begin
			end
		endcase
	end

	rld_vector #(
		.SENSORS(SENSORS)
	) u_vector (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.sx       (sx_q),
		.sy       (sy_q),
		.done     (vec_done),
		.direction(vec_dir)
	);

	// an accepted frame starts the scan
	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid && frame.ready |=> state_q == ST_SCAN)
		else $error("accepted frame did not start the scan");

	// the sum phase only runs for a partial run
	a_sum_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SUM |-> len_q != '0 && len_q < LW'(SENSORS))
		else $error("vector sum entered with empty or full run");

	// the CORDIC only reports while the sequencer waits for it
	a_vec_done: assert property (@(posedge clk) disable iff (!arst_n)
		vec_done |-> state_q == ST_VECT)
		else $error("CORDIC finished outside the vector phase");

	// a clear ring gives a zero direction and run length
	a_no_ball: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.data.ball_seen |->
			result.data.direction == '0 && result.data.run_length == '0)
		else $error("clear ring reported a run or direction");

endmodule
